@@ src/lsds_pkg.sv @@
`default_nettype none

package lsds_pkg;

   // Field widths of the request and response channels
   localparam int OP_WIDTH     = 3;
   localparam int PUSH_WIDTH   = 32;
   localparam int READ_WIDTH   = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 7;

   // Operation codes
   localparam logic [OP_WIDTH-1:0] OP_PUSH  = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_POP   = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_PEEK  = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_DUP   = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_SWAP  = 3'd4;
   localparam logic [OP_WIDTH-1:0] OP_CLEAR = 3'd5;

   // Status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_UNDER = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_OVER  = 2'd2;

   // Per-cell control: load a new word, taken from the neighbour above
   // (towards the top of the stack) or from the neighbour below.
   typedef struct packed {
      logic load;
      logic from_above;
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ src/lsds_if.sv @@
`default_nettype none

interface lsds_req_if import lsds_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OP_WIDTH-1:0]   op;
   logic [PUSH_WIDTH-1:0] push_value;

   modport source (output valid, output op, output push_value, input ready);
   modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface lsds_rsp_if import lsds_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [READ_WIDTH-1:0]   read_word;
   logic [STATUS_WIDTH-1:0] status;
   logic [COUNT_WIDTH-1:0]  entry_count;
   logic                    is_empty;

   modport source (output valid, output read_word, output status,
                   output entry_count, output is_empty, input ready);
   modport sink   (input valid, input read_word, input status,
                   input entry_count, input is_empty, output ready);
endinterface

`default_nettype wire

@@ src/lsds_cell.sv @@
`default_nettype none

module lsds_cell import lsds_pkg::*; #(
   parameter int WORD_WIDTH = 32
) (
   input  wire                   clock,
   input  wire cell_ctl_type     ctl,
   input  wire  [WORD_WIDTH-1:0] above_word,
   input  wire  [WORD_WIDTH-1:0] below_word,
   output logic [WORD_WIDTH-1:0] word
);

   logic [WORD_WIDTH-1:0] word_ff;
   logic [WORD_WIDTH-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.load) begin
         word_in = ctl.from_above ? above_word : below_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

`default_nettype wire

@@ src/lifo_stack_with_dup_swap.sv @@
`default_nettype none

// LIFO stack of DEPTH words of WORD_WIDTH bits, built as a row of word cells
// in which cell 0 always holds the top of the stack. Push and duplicate move
// every cell one place down the row, pop moves every cell one place up, swap
// exchanges cells 0 and 1, and clear just zeroes the entry count, so every
// operation is finished in the cycle its request is accepted. Each request
// gives exactly one response: the popped or peeked word (zero otherwise), a
// status (ok, underflow, overflow), the entry count afterwards and an empty
// flag. Throughput is one request per clock unless stalled; the response
// appears in the cycle after acceptance. The single response register sets
// that rate: a request is taken whenever that register is empty or is being
// drained in the same cycle. push_value is cut or zero-extended to WORD_WIDTH;
// read_word and entry_count carry the low bits of the word and count.
module lifo_stack_with_dup_swap import lsds_pkg::*; #(
   parameter int DEPTH      = 64,
   parameter int WORD_WIDTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   lsds_req_if.sink    req_ch,
   lsds_rsp_if.source  rsp_ch
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   // Row movement codes for the current request
   localparam logic [2:0] MOVE_HOLD = 3'd0;
   localparam logic [2:0] MOVE_PUSH = 3'd1;
   localparam logic [2:0] MOVE_POP  = 3'd2;
   localparam logic [2:0] MOVE_DUP  = 3'd3;
   localparam logic [2:0] MOVE_SWAP = 3'd4;

   // Control state
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;

   // Response payload register
   logic [READ_WIDTH-1:0]   read_word_ff;
   logic [STATUS_WIDTH-1:0] status_ff;
   logic [COUNT_WIDTH-1:0]  entry_count_ff;
   logic                    is_empty_ff;

   logic                    accept;
   logic [2:0]              move;
   logic [STATUS_WIDTH-1:0] status_in;
   logic [WORD_WIDTH-1:0]   read_in;
   logic [WORD_WIDTH-1:0]   new_word;
   logic                    is_full;
   logic                    is_zero;
   logic                    has_two;

   logic [WORD_WIDTH-1:0]   cell_word [DEPTH];
   cell_ctl_type            cell_ctl  [DEPTH];

   // Take a request whenever the response register is free or draining
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign new_word = WORD_WIDTH'(req_ch.push_value);
   assign is_full  = (count_ff == FULL_COUNT);
   assign is_zero  = (count_ff == '0);
   assign has_two  = (count_ff >= CNT_W'(2));

   // Decode the operation against the current fill level
   always_comb begin
      move      = MOVE_HOLD;
      status_in = ST_OK;
      read_in   = '0;
      count_in  = count_ff;
      unique case (req_ch.op)
         OP_PUSH: begin
            if (is_full) begin
               status_in = ST_OVER;
            end else begin
               move     = MOVE_PUSH;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_POP: begin
            if (is_zero) begin
               status_in = ST_UNDER;
            end else begin
               move     = MOVE_POP;
               read_in  = cell_word[0];
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_PEEK: begin
            if (is_zero) begin
               status_in = ST_UNDER;
            end else begin
               read_in = cell_word[0];
            end
         end
         OP_DUP: begin
            if (is_zero) begin
               status_in = ST_UNDER;
            end else if (is_full) begin
               status_in = ST_OVER;
            end else begin
               move     = MOVE_DUP;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_SWAP: begin
            if (!has_two) begin
               status_in = ST_UNDER;
            end else begin
               move = MOVE_SWAP;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            // unused codes: leave everything as it is
         end
      endcase
      if (!accept) begin
         move     = MOVE_HOLD;
         count_in = count_ff;
      end
   end

   // Row of cells: cell 0 is the top, higher indices lie deeper
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] above_word;
      logic [WORD_WIDTH-1:0] below_word;

      if (i == 0) begin : g_top
         assign above_word = new_word;
      end else begin : g_inner_a
         assign above_word = cell_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_bottom
         assign below_word = cell_word[i];
      end else begin : g_inner_b
         assign below_word = cell_word[i+1];
      end

      always_comb begin
         cell_ctl[i] = '0;
         unique case (move)
            MOVE_PUSH: begin
               cell_ctl[i].load       = 1'b1;
               cell_ctl[i].from_above = 1'b1;
            end
            MOVE_POP: begin
               cell_ctl[i].load = 1'b1;
            end
            MOVE_DUP: begin
               // top keeps its word, its copy goes into cell 1
               cell_ctl[i].load       = (i != 0);
               cell_ctl[i].from_above = 1'b1;
            end
            MOVE_SWAP: begin
               cell_ctl[i].load       = (i < 2);
               cell_ctl[i].from_above = (i == 1);
            end
            default: begin
               cell_ctl[i] = '0;
            end
         endcase
      end

      lsds_cell #(
         .WORD_WIDTH (WORD_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .above_word (above_word),
         .below_word (below_word),
         .word       (cell_word[i])
      );
   end

   // Hold the response until taken; load a fresh one on each accepted request
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_word_ff   <= READ_WIDTH'(read_in);
         status_ff      <= status_in;
         entry_count_ff <= COUNT_WIDTH'(count_in);
         is_empty_ff    <= (count_in == '0);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_word   = read_word_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.entry_count = entry_count_ff;
   assign rsp_ch.is_empty    = is_empty_ff;

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond depth");

   a_push_lands_on_top: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.op == OP_PUSH && !is_full |=> cell_word[0] == $past(new_word))
      else $error("pushed word not on top");

   a_overflow_only_full: assert property (@(posedge clock) disable iff (reset)
      accept && status_in == ST_OVER |=> count_ff == FULL_COUNT)
      else $error("overflow reported below full");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request without response");
`endif

endmodule

`default_nettype wire
